>>> hw/rtl/lsacl_pkg.sv
`timescale 1ns / 1ps

package lsacl_pkg;

   localparam int MAX_SETS   = 64;
   localparam int MAX_WAYS   = 8;
   localparam int ADDR_WIDTH = 32;

   localparam int SET_W      = $clog2(MAX_SETS);
   localparam int WAY_W      = $clog2(MAX_WAYS);
   localparam int AGE_W      = WAY_W;
   localparam int WAYCNT_W   = $clog2(MAX_WAYS + 1);
   localparam int MAX_IBITS  = SET_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ADDRESS_BITS = 2'd0,
      CSR_OFFSET_BITS  = 2'd1,
      CSR_INDEX_BITS   = 2'd2,
      CSR_WAYS_IN_USE  = 2'd3
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   // one set of the tag store
   typedef struct packed {
      logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
      logic [MAX_WAYS-1:0][AGE_W-1:0]      age;
      logic [MAX_WAYS-1:0]                 valid;
   } set_row_type;

endpackage

>>> hw/rtl/lsacl_ctrl.sv
`timescale 1ns / 1ps

module lsacl_ctrl
   import lsacl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            busy       = 1'b1;
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/lsacl_dpath.sv
`timescale 1ns / 1ps

module lsacl_dpath
   import lsacl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   input  logic [ADDR_WIDTH-1:0] req_address,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [SET_W-1:0]      rsp_set_index,
   output logic [31:0]           rsp_miss_count
);

   localparam int ABITS_W = $clog2(ADDR_WIDTH + 1);
   localparam int SHAMT_W = $clog2(ADDR_WIDTH + MAX_IBITS + 1);

   // configuration
   logic [5:0] address_bits_ff;
   logic [4:0] offset_bits_ff;
   logic [2:0] index_bits_ff;
   logic [3:0] ways_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_bits_ff <= 6'd32;
         offset_bits_ff  <= 5'd2;
         index_bits_ff   <= 3'd2;
         ways_in_use_ff  <= 4'd2;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ADDRESS_BITS: address_bits_ff <= csr_wdata[5:0];
            CSR_OFFSET_BITS:  offset_bits_ff  <= csr_wdata[4:0];
            CSR_INDEX_BITS:   index_bits_ff   <= csr_wdata[2:0];
            CSR_WAYS_IN_USE:  ways_in_use_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // address split
   logic [ABITS_W-1:0]    abits;
   logic [ADDR_WIDTH-1:0] addr_mask;
   logic [ADDR_WIDTH-1:0] addr_m;
   logic [2:0]            ibits;
   logic [SET_W-1:0]      set_mask;
   logic [SET_W-1:0]      set_in;
   logic [SHAMT_W-1:0]    tag_shamt;
   logic [ADDR_WIDTH-1:0] tag_in;

   always_comb begin
      abits     = (address_bits_ff > 6'(ADDR_WIDTH)) ? ABITS_W'(ADDR_WIDTH)
                                                     : ABITS_W'(address_bits_ff);
      addr_mask = (abits >= ABITS_W'(ADDR_WIDTH)) ? '1
                                                  : ((ADDR_WIDTH'(1) << abits) - 1'b1);
      addr_m    = req_address & addr_mask;
      ibits     = (index_bits_ff > 3'(MAX_IBITS)) ? 3'(MAX_IBITS) : index_bits_ff;
      set_mask  = SET_W'(((SET_W+1)'(1) << ibits) - 1'b1);
      set_in    = SET_W'(addr_m >> offset_bits_ff) & set_mask;
      tag_shamt = SHAMT_W'(offset_bits_ff) + SHAMT_W'(ibits);
      tag_in    = (tag_shamt >= SHAMT_W'(ADDR_WIDTH)) ? '0 : (addr_m >> tag_shamt);
   end

   // tag store: one row per set, rows never written read as empty
   set_row_type           mem [MAX_SETS];
   logic [MAX_SETS-1:0]   row_written_ff;
   set_row_type           rd_row_ff;
   logic                  row_ok_ff;
   logic [SET_W-1:0]      set_ff;
   logic [ADDR_WIDTH-1:0] tag_ff;
   set_row_type           row_new;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_row_ff <= mem[set_in];
      end
      if (cmd.commit) begin
         mem[set_ff] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         set_ff    <= set_in;
         tag_ff    <= tag_in;
         row_ok_ff <= row_written_ff[set_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_written_ff <= '0;
      end else if (cmd.commit) begin
         row_written_ff[set_ff] <= 1'b1;
      end
   end

   // lookup and LRU update
   logic [WAYCNT_W-1:0] ways;
   set_row_type         row_cur;
   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] hit_vec;
   logic [MAX_WAYS-1:0] empty_vec;
   logic                hit;
   logic                has_empty;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    empty_way;
   logic [WAY_W-1:0]    victim;
   logic [WAY_W-1:0]    ref_way;
   logic [AGE_W:0]      limit;

   always_comb begin
      if (ways_in_use_ff == 4'd0) begin
         ways = WAYCNT_W'(1);
      end else if (ways_in_use_ff > 4'(MAX_WAYS)) begin
         ways = WAYCNT_W'(MAX_WAYS);
      end else begin
         ways = WAYCNT_W'(ways_in_use_ff);
      end

      row_cur = rd_row_ff;
      if (!row_ok_ff) begin
         row_cur.valid = '0;
         row_cur.age   = '0;
      end

      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w]    = WAYCNT_W'(w) < ways;
         hit_vec[w]   = in_use[w] && row_cur.valid[w] && (row_cur.tag[w] == tag_ff);
         empty_vec[w] = in_use[w] && !row_cur.valid[w];
      end
      hit       = |hit_vec;
      has_empty = |empty_vec;

      // lowest-numbered match and lowest-numbered empty way
      hit_way   = '0;
      empty_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (empty_vec[w]) begin
            empty_way = WAY_W'(w);
         end
      end

      // oldest way, lowest index on ties
      victim = '0;
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (in_use[w] && (row_cur.age[w] > row_cur.age[victim])) begin
            victim = WAY_W'(w);
         end
      end

      if (hit) begin
         ref_way = hit_way;
         limit   = {1'b0, row_cur.age[hit_way]};
      end else if (has_empty) begin
         ref_way = empty_way;
         limit   = (AGE_W+1)'(MAX_WAYS);
      end else begin
         ref_way = victim;
         limit   = (AGE_W+1)'(MAX_WAYS);
      end

      row_new = row_cur;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (in_use[w] && (WAY_W'(w) != ref_way) && row_cur.valid[w]
             && ({1'b0, row_cur.age[w]} < limit)) begin
            if (row_cur.age[w] != AGE_W'(MAX_WAYS - 1)) begin
               row_new.age[w] = row_cur.age[w] + 1'b1;
            end
         end
      end
      row_new.age[ref_way] = '0;
      if (!hit) begin
         row_new.tag[ref_way]   = tag_ff;
         row_new.valid[ref_way] = 1'b1;
      end
   end

   // results
   logic        rsp_valid_ff;
   logic        rsp_hit_ff;
   logic [SET_W-1:0] rsp_set_ff;
   logic [31:0] miss_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         miss_cnt_ff  <= '0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit && !hit && (miss_cnt_ff != '1)) begin
            miss_cnt_ff <= miss_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff <= hit;
         rsp_set_ff <= set_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_set_index  = rsp_set_ff;
   assign rsp_miss_count = miss_cnt_ff;

endmodule

>>> hw/rtl/lru_set_assoc_cache_lookup.sv
`timescale 1ns / 1ps
// Channel   Ports                                         Handshake
// -------   -------------------------------------------   ---------------------------
// request   req_address                                   start high, busy low
// result    rsp_hit, rsp_set_index, rsp_miss_count        rsp_valid, one-cycle strobe
// config    csr_index, csr_wdata                          csr_we, written at once
//
// For each item, the set row is read from the tag store RAM at
// acceptance, compared and written back in the following cycle, while busy is high.
// Start is ignored while busy is high; each result strobes in the cycle after busy.
// Reset clears the per-set written flags at once, so every row reads as empty; no clearing pass is needed.
// The receiver cannot stall: results are presented for exactly one cycle.

module lru_set_assoc_cache_lookup
   import lsacl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ADDR_WIDTH-1:0] req_address,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [SET_W-1:0]      rsp_set_index,
   output logic [31:0]           rsp_miss_count,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type cmd;

   lsacl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lsacl_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_address    (req_address),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_set_index  (rsp_set_index),
      .rsp_miss_count (rsp_miss_count)
   );

endmodule
